FILE: design/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg: shared types and constants for the quaternion ALU
// Word format (signed Q3.F), action codes, payload structs and the
// control group passed between the product and sum stages.
// ----------------------------------------------------------------------------
package qalu_pkg;

	// Word format
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = DATA_WIDTH - 4;
	localparam int PROD_W     = 2 * DATA_WIDTH;          // full product
	localparam int RND_W      = PROD_W - FRAC_BITS;      // rounded product
	localparam int SUM_W      = RND_W + 2;               // sum of four terms
	localparam int LANES      = 4;                       // terms per component
	localparam int COMPS      = 4;                       // quaternion components

	// 1.0 in Q3.F, used to pass a word through a multiplier lane unchanged
	localparam logic signed [DATA_WIDTH-1:0] ONE_Q = {4'b0001, {FRAC_BITS{1'b0}}};

	// Half an LSB of the rounded product, added before truncation
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	// Action codes; the two spare codes give an all-zero result
	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_SUB    = 3'd1,
		ACT_LIN    = 3'd2,
		ACT_CONJ   = 3'd3,
		ACT_MUL    = 3'd4,
		ACT_DOT    = 3'd5,
		ACT_SPARE6 = 3'd6,
		ACT_SPARE7 = 3'd7
	} action_t;

	// Input item
	typedef struct packed {
		logic [2:0]                    action;
		logic signed [DATA_WIDTH-1:0]  q_w;
		logic signed [DATA_WIDTH-1:0]  q_x;
		logic signed [DATA_WIDTH-1:0]  q_y;
		logic signed [DATA_WIDTH-1:0]  q_z;
		logic signed [DATA_WIDTH-1:0]  r_w;
		logic signed [DATA_WIDTH-1:0]  r_x;
		logic signed [DATA_WIDTH-1:0]  r_y;
		logic signed [DATA_WIDTH-1:0]  r_z;
		logic signed [DATA_WIDTH-1:0]  coef_q;
		logic signed [DATA_WIDTH-1:0]  coef_r;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  out_w;
		logic signed [DATA_WIDTH-1:0]  out_x;
		logic signed [DATA_WIDTH-1:0]  out_y;
		logic signed [DATA_WIDTH-1:0]  out_z;
		logic                          saturated;
	} out_item_t;

	// Rounded products, [component][lane]
	typedef logic [COMPS-1:0][LANES-1:0][RND_W-1:0] prod_set_t;

	// Control between product and sum stages
	typedef struct packed {
		logic                            valid;
		logic [COMPS-1:0][LANES-1:0]     neg;
	} lane_ctrl_t;

endpackage

FILE: design/qalu_prod.sv
// ----------------------------------------------------------------------------
// qalu_prod: operand routing and rounded multiplier lanes
// Maps each action onto sixteen multiplier lanes (four per component),
// rounds each product to F fraction bits and registers the results.
// ----------------------------------------------------------------------------
module qalu_prod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  qalu_pkg::in_item_t   item_s1,
	output qalu_pkg::prod_set_t  prod_s2,
	output qalu_pkg::lane_ctrl_t ctrl_s2
);

	logic signed [qalu_pkg::DATA_WIDTH-1:0] q [qalu_pkg::COMPS];
	logic signed [qalu_pkg::DATA_WIDTH-1:0] r [qalu_pkg::COMPS];
	logic signed [qalu_pkg::DATA_WIDTH-1:0] op_a [qalu_pkg::COMPS][qalu_pkg::LANES];
	logic signed [qalu_pkg::DATA_WIDTH-1:0] op_b [qalu_pkg::COMPS][qalu_pkg::LANES];
	logic [qalu_pkg::COMPS-1:0][qalu_pkg::LANES-1:0] neg;
	logic signed [qalu_pkg::PROD_W-1:0] full [qalu_pkg::COMPS][qalu_pkg::LANES];
	logic signed [qalu_pkg::PROD_W-1:0] rnd  [qalu_pkg::COMPS][qalu_pkg::LANES];
	logic [qalu_pkg::COMPS-1:0][qalu_pkg::LANES-1:0] neg_s2;
	logic                                            valid_s2;

	// Operand routing per action; unused lanes multiply zero by zero
	always_comb begin
		q[0] = item_s1.q_w;
		q[1] = item_s1.q_x;
		q[2] = item_s1.q_y;
		q[3] = item_s1.q_z;
		r[0] = item_s1.r_w;
		r[1] = item_s1.r_x;
		r[2] = item_s1.r_y;
		r[3] = item_s1.r_z;
		neg  = '0;
		for (int c = 0; c < qalu_pkg::COMPS; c++) begin
			for (int k = 0; k < qalu_pkg::LANES; k++) begin
				op_a[c][k] = '0;
				op_b[c][k] = '0;
			end
		end
		case (item_s1.action)
			qalu_pkg::ACT_ADD, qalu_pkg::ACT_SUB: begin
				for (int c = 0; c < qalu_pkg::COMPS; c++) begin
					op_a[c][0] = q[c];
					op_b[c][0] = qalu_pkg::ONE_Q;
					op_a[c][1] = r[c];
					op_b[c][1] = qalu_pkg::ONE_Q;
					neg[c][1]  = (item_s1.action == qalu_pkg::ACT_SUB);
				end
			end
			qalu_pkg::ACT_LIN: begin
				for (int c = 0; c < qalu_pkg::COMPS; c++) begin
					op_a[c][0] = item_s1.coef_q;
					op_b[c][0] = q[c];
					op_a[c][1] = item_s1.coef_r;
					op_b[c][1] = r[c];
				end
			end
			qalu_pkg::ACT_CONJ: begin
				for (int c = 0; c < qalu_pkg::COMPS; c++) begin
					op_a[c][0] = q[c];
					op_b[c][0] = qalu_pkg::ONE_Q;
					neg[c][0]  = (c != 0);
				end
			end
			qalu_pkg::ACT_MUL: begin
				// Hamilton product: w
				op_a[0][0] = q[0]; op_b[0][0] = r[0];
				op_a[0][1] = q[1]; op_b[0][1] = r[1]; neg[0][1] = 1'b1;
				op_a[0][2] = q[2]; op_b[0][2] = r[2]; neg[0][2] = 1'b1;
				op_a[0][3] = q[3]; op_b[0][3] = r[3]; neg[0][3] = 1'b1;
				// i
				op_a[1][0] = q[0]; op_b[1][0] = r[1];
				op_a[1][1] = q[1]; op_b[1][1] = r[0];
				op_a[1][2] = q[2]; op_b[1][2] = r[3];
				op_a[1][3] = q[3]; op_b[1][3] = r[2]; neg[1][3] = 1'b1;
				// j
				op_a[2][0] = q[0]; op_b[2][0] = r[2];
				op_a[2][1] = q[2]; op_b[2][1] = r[0];
				op_a[2][2] = q[3]; op_b[2][2] = r[1];
				op_a[2][3] = q[1]; op_b[2][3] = r[3]; neg[2][3] = 1'b1;
				// k
				op_a[3][0] = q[0]; op_b[3][0] = r[3];
				op_a[3][1] = q[3]; op_b[3][1] = r[0];
				op_a[3][2] = q[1]; op_b[3][2] = r[2];
				op_a[3][3] = q[2]; op_b[3][3] = r[1]; neg[3][3] = 1'b1;
			end
			qalu_pkg::ACT_DOT: begin
				for (int k = 0; k < qalu_pkg::LANES; k++) begin
					op_a[0][k] = q[k];
					op_b[0][k] = r[k];
				end
			end
			default: begin
				// unused codes: all lanes stay zero
			end
		endcase
	end

	// Multiplier lanes: signed product, add half an LSB, floor
	for (genvar gc = 0; gc < qalu_pkg::COMPS; gc++) begin : g_comp
		for (genvar gk = 0; gk < qalu_pkg::LANES; gk++) begin : g_lane
			assign full[gc][gk] = op_a[gc][gk] * op_b[gc][gk];
			assign rnd[gc][gk]  = full[gc][gk] + qalu_pkg::ROUND_HALF;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		for (int c = 0; c < qalu_pkg::COMPS; c++) begin
			for (int k = 0; k < qalu_pkg::LANES; k++) begin
				prod_s2[c][k] <= rnd[c][k][qalu_pkg::PROD_W-1:qalu_pkg::FRAC_BITS];
			end
		end
		neg_s2 <= neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	assign ctrl_s2 = '{valid: valid_s2, neg: neg_s2};

endmodule

FILE: design/qalu_sum.sv
// ----------------------------------------------------------------------------
// qalu_sum: term summation and saturation
// Adds or subtracts the four rounded products of each component, clips
// each sum to the word range and registers the result with its strobe.
// ----------------------------------------------------------------------------
module qalu_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qalu_pkg::prod_set_t  prod_s2,
	input  qalu_pkg::lane_ctrl_t ctrl_s2,
	output logic                 done,
	output qalu_pkg::out_item_t  result
);

	localparam int W = qalu_pkg::DATA_WIDTH;

	logic signed [qalu_pkg::SUM_W-1:0] acc [qalu_pkg::COMPS];
	logic signed [W-1:0]              clip [qalu_pkg::COMPS];
	logic [qalu_pkg::COMPS-1:0]       ovf;
	logic                             done_q;
	qalu_pkg::out_item_t              result_q;

	// Signed sum of four terms per component, then clip
	always_comb begin
		for (int c = 0; c < qalu_pkg::COMPS; c++) begin
			acc[c] = '0;
			for (int k = 0; k < qalu_pkg::LANES; k++) begin
				if (ctrl_s2.neg[c][k]) begin
					acc[c] = acc[c] - qalu_pkg::SUM_W'($signed(prod_s2[c][k]));
				end else begin
					acc[c] = acc[c] + qalu_pkg::SUM_W'($signed(prod_s2[c][k]));
				end
			end
			// out of range when the bits above the word are not a sign extension
			ovf[c] = !((&acc[c][qalu_pkg::SUM_W-1:W-1]) || !(|acc[c][qalu_pkg::SUM_W-1:W-1]));
			if (ovf[c]) begin
				clip[c] = acc[c][qalu_pkg::SUM_W-1] ? {1'b1, {(W-1){1'b0}}}
				                                    : {1'b0, {(W-1){1'b1}}};
			end else begin
				clip[c] = acc[c][W-1:0];
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			result_q.out_w     <= clip[0];
			result_q.out_x     <= clip[1];
			result_q.out_y     <= clip[2];
			result_q.out_z     <= clip[3];
			result_q.saturated <= |ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s2.valid;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: design/quaternion_alu.sv
// ----------------------------------------------------------------------------
// quaternion_alu: fixed-point quaternion arithmetic unit (top level)
// Add, subtract, linear combination, conjugate, Hamilton product and dot
// product on signed Q3.28 words, with rounded products and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive operands and raise start; the transfer happens at
//   a rising edge where start is high and busy is low. busy is high only
//   from reset until the first clock edge after reset is released, so once
//   running one item can be taken at every edge.
//   Result channel: done is high for exactly one cycle with the result on
//   the result port; the receiver must take it in that cycle.
//   Pipeline: an item taken at an edge is registered in the input register,
//   its sixteen rounded products in the product register and its result
//   in the result register; done is registered together with the result.
//   Throughput: one item per cycle once busy is low, set by the sixteen parallel multiplier
//   lanes, each used once per item.
//   Reset: arst_n clears all strobes and sets busy; items in flight are
//   dropped. Payload registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  qalu_pkg::in_item_t  operands,
	output logic                done,
	output qalu_pkg::out_item_t result
);

	logic                 busy_q;
	logic                 valid_s1;
	qalu_pkg::in_item_t   item_s1;
	qalu_pkg::prod_set_t  prod_s2;
	qalu_pkg::lane_ctrl_t ctrl_s2;
	logic                 take;

	assign take = start && !busy_q;
	assign busy = busy_q;

	// Busy only while coming out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= take;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= operands;
		end
	end

	qalu_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.prod_s2  (prod_s2),
		.ctrl_s2  (ctrl_s2)
	);

	qalu_sum u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod_s2 (prod_s2),
		.ctrl_s2 (ctrl_s2),
		.done    (done),
		.result  (result)
	);

`ifndef SYNTHESIS
	// Every transfer is followed by a product stage item and then a result strobe
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 ctrl_s2.valid ##1 done)
		else $error("transfer did not produce a result strobe");

	// No result without a product stage item behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctrl_s2.valid))
		else $error("result strobe without a pending item");

	// Dot product leaves the vector part zero
	a_dot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(item_s1.action, 2) == qalu_pkg::ACT_DOT) |->
		(result.out_x == '0 && result.out_y == '0 && result.out_z == '0))
		else $error("dot result has nonzero vector part");

	// Unused action codes give an all-zero result
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(item_s1.action, 2) == qalu_pkg::ACT_SPARE6 ||
		          $past(item_s1.action, 2) == qalu_pkg::ACT_SPARE7))
		|-> (result == '0))
		else $error("unused action produced a nonzero result");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the quaternion ALU
// A directed table of corner cases (word extremes, saturation on every
// action, rounding ties, unused action codes) is followed by random
// operand sets with random start gaps. Each result is compared with the
// expected result written in its table row or with a bit-accurate model of the Q3.F arithmetic kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH  = 3;      // registers from transfer to result
	localparam int STALL_LIMIT = 1000;   // cycles with no transfer at all
	localparam int RAND_ITEMS  = 450;

	typedef logic signed [qalu_pkg::DATA_WIDTH-1:0]   word_t;
	typedef logic signed [2*qalu_pkg::DATA_WIDTH+3:0] acc_t;   // exact sums of products

	localparam word_t W_MAX = {1'b0, {(qalu_pkg::DATA_WIDTH-1){1'b1}}};
	localparam word_t W_MIN = {1'b1, {(qalu_pkg::DATA_WIDTH-1){1'b0}}};
	localparam word_t ONE   = qalu_pkg::ONE_Q;
	localparam word_t HALF  = word_t'(1) <<< (qalu_pkg::FRAC_BITS - 1);   // 0.5 in Q3.F
	localparam word_t FOUR  = word_t'(4) <<< qalu_pkg::FRAC_BITS;
	localparam word_t JUNK  = word_t'(32'hA5C3_5A3C);

	typedef struct {
		qalu_pkg::in_item_t  op;
		bit                  typed;   // expected result written in the row
		qalu_pkg::out_item_t res;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	qalu_pkg::in_item_t  operands;
	logic                done;
	qalu_pkg::out_item_t result;

	qalu_pkg::out_item_t awaited_results[$];
	plan_row_t           plan[$];
	int                  mismatches   = 0;
	int                  stall_cycles = 0;

	quaternion_alu dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Fixed-point model
	// ------------------------------------------------------------------

	// Product rounded to F fraction bits, ties toward plus infinity
	function automatic acc_t fx_mul(input word_t a, input word_t b);
		acc_t p;
		p = acc_t'(a) * acc_t'(b);
		return (p + (acc_t'(1) <<< (qalu_pkg::FRAC_BITS - 1))) >>> qalu_pkg::FRAC_BITS;
	endfunction

	function automatic word_t fx_clip(input acc_t v, inout logic sat);
		if (v > acc_t'(W_MAX)) begin
			sat = 1'b1;
			return W_MAX;
		end
		if (v < acc_t'(W_MIN)) begin
			sat = 1'b1;
			return W_MIN;
		end
		return word_t'(v);
	endfunction

	function automatic qalu_pkg::out_item_t quat_result(input qalu_pkg::in_item_t it);
		word_t               q[4];
		word_t               r[4];
		acc_t                res[4];
		logic                sat;
		qalu_pkg::out_item_t o;
		q = '{it.q_w, it.q_x, it.q_y, it.q_z};
		r = '{it.r_w, it.r_x, it.r_y, it.r_z};
		for (int k = 0; k < 4; k++)
			res[k] = '0;
		case (it.action)
			qalu_pkg::ACT_ADD:
				for (int k = 0; k < 4; k++)
					res[k] = acc_t'(q[k]) + acc_t'(r[k]);
			qalu_pkg::ACT_SUB:
				for (int k = 0; k < 4; k++)
					res[k] = acc_t'(q[k]) - acc_t'(r[k]);
			qalu_pkg::ACT_LIN:
				for (int k = 0; k < 4; k++)
					res[k] = fx_mul(it.coef_q, q[k]) + fx_mul(it.coef_r, r[k]);
			qalu_pkg::ACT_CONJ: begin
				res[0] = acc_t'(q[0]);
				for (int k = 1; k < 4; k++)
					res[k] = -acc_t'(q[k]);
			end
			qalu_pkg::ACT_MUL: begin
				res[0] = fx_mul(q[0], r[0]) - fx_mul(q[1], r[1])
				       - fx_mul(q[2], r[2]) - fx_mul(q[3], r[3]);
				res[1] = fx_mul(q[0], r[1]) + fx_mul(q[1], r[0])
				       + fx_mul(q[2], r[3]) - fx_mul(q[3], r[2]);
				res[2] = fx_mul(q[0], r[2]) + fx_mul(q[2], r[0])
				       + fx_mul(q[3], r[1]) - fx_mul(q[1], r[3]);
				res[3] = fx_mul(q[0], r[3]) + fx_mul(q[3], r[0])
				       + fx_mul(q[1], r[2]) - fx_mul(q[2], r[1]);
			end
			qalu_pkg::ACT_DOT:
				res[0] = fx_mul(q[0], r[0]) + fx_mul(q[1], r[1])
				       + fx_mul(q[2], r[2]) + fx_mul(q[3], r[3]);
			default: ;   // spare codes give an all-zero result
		endcase
		sat = 1'b0;
		o.out_w = fx_clip(res[0], sat);
		o.out_x = fx_clip(res[1], sat);
		o.out_y = fx_clip(res[2], sat);
		o.out_z = fx_clip(res[3], sat);
		o.saturated = sat;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic qalu_pkg::in_item_t op_of(input logic [2:0] act,
			input word_t qw, input word_t qx, input word_t qy, input word_t qz,
			input word_t rw, input word_t rx, input word_t ry, input word_t rz,
			input word_t cq, input word_t cr);
		qalu_pkg::in_item_t it;
		it.action = act;
		it.q_w = qw; it.q_x = qx; it.q_y = qy; it.q_z = qz;
		it.r_w = rw; it.r_x = rx; it.r_y = ry; it.r_z = rz;
		it.coef_q = cq;
		it.coef_r = cr;
		return it;
	endfunction

	function automatic qalu_pkg::out_item_t res_of(input word_t w, input word_t x,
			input word_t y, input word_t z, input logic sat);
		qalu_pkg::out_item_t o;
		o.out_w = w; o.out_x = x; o.out_y = y; o.out_z = z;
		o.saturated = sat;
		return o;
	endfunction

	// Mix of full-range words, values near the unit range, extremes, a few LSBs and plus or minus one
	function automatic word_t rand_word();
		case ($urandom_range(0, 10))
			0, 1, 2, 3: return word_t'($urandom);
			4, 5, 6:    return word_t'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
			7:          return W_MAX;
			8:          return W_MIN;
			9:          return word_t'(int'($urandom_range(0, 16)) - 8);
			default:    return $urandom_range(0, 1) ? ONE : -ONE;
		endcase
	endfunction

	function automatic qalu_pkg::in_item_t random_op();
		qalu_pkg::in_item_t it;
		if ($urandom_range(0, 9) == 0)
			it.action = $urandom_range(0, 1) ? qalu_pkg::ACT_SPARE7 : qalu_pkg::ACT_SPARE6;
		else
			it.action = 3'($urandom_range(qalu_pkg::ACT_ADD, qalu_pkg::ACT_DOT));
		it.q_w = rand_word(); it.q_x = rand_word();
		it.q_y = rand_word(); it.q_z = rand_word();
		it.r_w = rand_word(); it.r_x = rand_word();
		it.r_y = rand_word(); it.r_z = rand_word();
		it.coef_q = rand_word();
		// plain scaling now and then
		it.coef_r = ($urandom_range(0, 3) == 0) ? '0 : rand_word();
		return it;
	endfunction

	// One transfer on the command side, with optional random gaps before it
	task automatic transfer(input qalu_pkg::in_item_t it, input bit typed,
			input qalu_pkg::out_item_t want, input bit gaps);
		while (gaps && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		operands <= it;
		do @(posedge clk); while (busy);
		awaited_results.push_back(typed ? want : quat_result(it));
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what,
			input logic [qalu_pkg::DATA_WIDTH-1:0] want,
			input logic [qalu_pkg::DATA_WIDTH-1:0] got);
		if (mismatches < 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		qalu_pkg::out_item_t want;
		if (done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("unexpected result", '0, result.out_w);
			end else begin
				want = awaited_results.pop_front();
				if (want.out_w !== result.out_w)
					note_mismatch("out_w", want.out_w, result.out_w);
				if (want.out_x !== result.out_x)
					note_mismatch("out_x", want.out_x, result.out_x);
				if (want.out_y !== result.out_y)
					note_mismatch("out_y", want.out_y, result.out_y);
				if (want.out_z !== result.out_z)
					note_mismatch("out_z", want.out_z, result.out_z);
				if (want.saturated !== result.saturated)
					note_mismatch("saturated", qalu_pkg::DATA_WIDTH'(want.saturated),
					              qalu_pkg::DATA_WIDTH'(result.saturated));
			end
		end
	end

	// Watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin : watchdog
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		qalu_pkg::out_item_t none;
		arst_n   = 1'b0;
		start    = 1'b0;
		operands = '0;
		none     = '0;

		// add: zero, both saturation directions, a general case
		plan.push_back('{op_of(qalu_pkg::ACT_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
		plan.push_back('{op_of(qalu_pkg::ACT_ADD, W_MAX, W_MAX, W_MAX, W_MAX,
			W_MAX, W_MAX, W_MAX, W_MAX, 0, 0), 1'b1, res_of(W_MAX, W_MAX, W_MAX, W_MAX, 1'b1)});
		plan.push_back('{op_of(qalu_pkg::ACT_ADD, W_MIN, W_MIN, W_MIN, W_MIN,
			W_MIN, W_MIN, W_MIN, W_MIN, 0, 0), 1'b1, res_of(W_MIN, W_MIN, W_MIN, W_MIN, 1'b1)});
		plan.push_back('{op_of(qalu_pkg::ACT_ADD, ONE, -ONE, HALF, 7, -3, ONE, W_MAX, -HALF,
			0, 0), 1'b0, none});
		// subtract across the extremes
		plan.push_back('{op_of(qalu_pkg::ACT_SUB, W_MIN, W_MIN, W_MIN, W_MIN,
			W_MAX, W_MAX, W_MAX, W_MAX, 0, 0), 1'b1, res_of(W_MIN, W_MIN, W_MIN, W_MIN, 1'b1)});
		plan.push_back('{op_of(qalu_pkg::ACT_SUB, W_MAX, W_MAX, W_MAX, W_MAX,
			W_MIN, W_MIN, W_MIN, W_MIN, 0, 0), 1'b1, res_of(W_MAX, W_MAX, W_MAX, W_MAX, 1'b1)});
		// conjugate: negating the most negative word clips
		plan.push_back('{op_of(qalu_pkg::ACT_CONJ, W_MIN, W_MIN, W_MIN, W_MIN,
			0, 0, 0, 0, 0, 0), 1'b1, res_of(W_MIN, W_MAX, W_MAX, W_MAX, 1'b1)});
		plan.push_back('{op_of(qalu_pkg::ACT_CONJ, 1, 2, 3, 4, 0, 0, 0, 0, 0, 0),
			1'b1, res_of(1, -2, -3, -4, 1'b0)});
		// linear combination: scaling by one half, extremes, largest positive
		plan.push_back('{op_of(qalu_pkg::ACT_LIN, ONE, -ONE, 3, -5, JUNK, JUNK, JUNK, JUNK,
			ONE >>> 1, 0), 1'b0, none});
		plan.push_back('{op_of(qalu_pkg::ACT_LIN, W_MIN, W_MIN, W_MIN, W_MIN,
			W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN), 1'b1,
			res_of(W_MAX, W_MAX, W_MAX, W_MAX, 1'b1)});
		plan.push_back('{op_of(qalu_pkg::ACT_LIN, W_MAX, W_MIN, W_MAX, W_MIN,
			W_MAX, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN), 1'b0, none});
		// Hamilton product: 1*1 = 1 and i*i = -1, then the extremes
		plan.push_back('{op_of(qalu_pkg::ACT_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0),
			1'b1, res_of(ONE, 0, 0, 0, 1'b0)});
		plan.push_back('{op_of(qalu_pkg::ACT_MUL, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0),
			1'b1, res_of(-ONE, 0, 0, 0, 1'b0)});
		plan.push_back('{op_of(qalu_pkg::ACT_MUL, W_MIN, W_MIN, W_MIN, W_MIN,
			W_MIN, W_MIN, W_MIN, W_MIN, 0, 0), 1'b0, none});
		plan.push_back('{op_of(qalu_pkg::ACT_MUL, W_MAX, W_MIN, W_MAX, W_MIN,
			W_MIN, W_MAX, W_MAX, W_MIN, 0, 0), 1'b0, none});
		// dot product: all-one operands and both saturation directions
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE,
			0, 0), 1'b1, res_of(FOUR, 0, 0, 0, 1'b0)});
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, W_MIN, W_MIN, W_MIN, W_MIN,
			W_MIN, W_MIN, W_MIN, W_MIN, 0, 0), 1'b1, res_of(W_MAX, 0, 0, 0, 1'b1)});
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, W_MIN, W_MIN, W_MIN, W_MIN,
			W_MAX, W_MAX, W_MAX, W_MAX, 0, 0), 1'b1, res_of(W_MIN, 0, 0, 0, 1'b1)});
		// product rounding: ties go up, just under a tie goes down
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, 1, 0, 0, 0, HALF, 0, 0, 0, 0, 0),
			1'b1, res_of(1, 0, 0, 0, 1'b0)});
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, -1, 0, 0, 0, HALF, 0, 0, 0, 0, 0),
			1'b1, res_of(0, 0, 0, 0, 1'b0)});
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, 1, 0, 0, 0, HALF - 1, 0, 0, 0, 0, 0),
			1'b1, res_of(0, 0, 0, 0, 1'b0)});
		plan.push_back('{op_of(qalu_pkg::ACT_DOT, -1, 0, 0, 0, HALF + 1, 0, 0, 0, 0, 0),
			1'b1, res_of(-1, 0, 0, 0, 1'b0)});
		// spare action codes ignore every operand
		plan.push_back('{op_of(qalu_pkg::ACT_SPARE6, JUNK, W_MIN, W_MAX, JUNK,
			W_MIN, JUNK, JUNK, W_MAX, JUNK, W_MIN), 1'b1, none});
		plan.push_back('{op_of(qalu_pkg::ACT_SPARE7, W_MAX, JUNK, W_MIN, W_MIN,
			JUNK, W_MAX, W_MIN, JUNK, W_MAX, JUNK), 1'b1, none});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			transfer(plan[i].op, plan[i].typed, plan[i].res, 1'b1);

		// random part; one long stretch issues back to back
		for (int n = 0; n < RAND_ITEMS; n++)
			transfer(random_op(), 1'b0, none, !(n >= 150 && n < 260));
		start <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
